// ===== hw/rtl/pmon_pkg.sv =====
package pmon_pkg;

  // Sequencer phases; codes 6 and 7 are unused and fall back to init
  typedef enum logic [2:0] {
    PH_INIT      = 3'd0,
    PH_SETCFG    = 3'd1,
    PH_READCFG   = 3'd2,
    PH_READBUS   = 3'd3,
    PH_READSHUNT = 3'd4,
    PH_IDLE      = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_WRITE_CFG  = 2'd0,
    KIND_READ_CFG   = 2'd1,
    KIND_READ_BUS   = 2'd2,
    KIND_READ_SHUNT = 2'd3
  } cmd_kind_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_DEVICE_ADDR = 1'b0,
    CFG_CONFIG_BYTE = 1'b1
  } cfg_reg_t;

  // Monitor register pointers
  localparam logic [7:0] REG_CONFIG = 8'h06;
  localparam logic [7:0] REG_BUS    = 8'h02;
  localparam logic [7:0] REG_SHUNT  = 8'h00;

  // Read lengths in bytes
  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_BYTE = 2'd1;
  localparam logic [1:0] LEN_WORD = 2'd2;

  typedef struct packed {
    logic        bus_idle;
    logic        bus_error;
    logic        bus_accepts;
    logic [15:0] read_data;
    logic        set_config_request;
  } item_t;

  typedef struct packed {
    logic               cmd_issue;
    logic [1:0]         cmd_kind;
    logic [7:0]         cmd_reg;
    logic [7:0]         cmd_write_byte;
    logic [1:0]         cmd_read_len;
    logic               data_valid;
    logic [15:0]        bus_voltage_raw;
    logic signed [15:0] shunt_current_raw;
  } result_t;

endpackage

// ===== hw/rtl/i2c_power_monitor_poll_sequencer.sv =====
// Poll sequencer for an I2C current/voltage monitor. Each input transfer is
// one poll tick carrying the master's status (bus_idle, bus_error,
// bus_accepts), the last read data and a set-config request bit; each tick
// yields exactly one output transfer with the command to issue (if any),
// data_valid and the latched raw bus and shunt words. Ticks with the master
// busy change nothing but the request latch. A bus error on an idle tick sends
// the sequencer back to init in that same tick (one on a busy tick is
// ignored); a refused issue sends it back to init on the next idle tick.
// Rate: one tick per clock cycle while the output is not stalled. Each tick
// passes through the input register, then the state step into the result
// register. A stalled output holds the result register, and one more tick
// can wait in the input register. Config writes (index 0 device address,
// index 1 config byte) are always accepted; the device address is consumed
// by the bus master itself and has no effect on any output here.
module i2c_power_monitor_poll_sequencer import pmon_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // tick input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               bus_idle,
  input  logic               bus_error,
  input  logic               bus_accepts,
  input  logic [15:0]        read_data,
  input  logic               set_config_request,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic               cmd_issue,
  output logic [1:0]         cmd_kind,
  output logic [7:0]         cmd_reg,
  output logic [7:0]         cmd_write_byte,
  output logic [1:0]         cmd_read_len,
  output logic               data_valid,
  output logic [15:0]        bus_voltage_raw,
  output logic signed [15:0] shunt_current_raw,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data
);

  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    in_take;
  result_t result_comb;
  result_t result;
  logic [7:0] config_byte;

  // control register: only the config byte is held here
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      config_byte <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CONFIG_BYTE: config_byte <= cfg_data;
        CFG_DEVICE_ADDR: config_byte <= config_byte;
        default:         config_byte <= config_byte;
      endcase
    end
  end

  // step when a tick is held and the result register is free or draining
  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= in_take || (item_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.bus_idle           <= bus_idle;
      item.bus_error          <= bus_error;
      item.bus_accepts        <= bus_accepts;
      item.read_data          <= read_data;
      item.set_config_request <= set_config_request;
    end
  end

  pmon_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item        (item),
    .config_byte (config_byte),
    .result      (result_comb)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) result <= result_comb;
  end

  assign cmd_issue         = result.cmd_issue;
  assign cmd_kind          = result.cmd_kind;
  assign cmd_reg           = result.cmd_reg;
  assign cmd_write_byte    = result.cmd_write_byte;
  assign cmd_read_len      = result.cmd_read_len;
  assign data_valid        = result.data_valid;
  assign bus_voltage_raw   = result.bus_voltage_raw;
  assign shunt_current_raw = result.shunt_current_raw;

endmodule

// ===== hw/rtl/pmon_seq.sv =====
module pmon_seq import pmon_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  item_t      item,
  input  logic [7:0] config_byte,
  output result_t    result
);

  phase_t      phase, phase_next;
  logic        entering, entering_next;
  logic        config_pending, config_pending_next;
  logic        fault, fault_next;
  logic [15:0] bus_word, bus_word_next;
  logic [15:0] shunt_word, shunt_word_next;

  logic pending_now;
  logic abort;

  // request bit is latched on every tick, busy ones included
  assign pending_now = config_pending | item.set_config_request;
  assign abort       = fault | item.bus_error;

  // next state
  always_comb begin
    phase_next          = phase;
    entering_next       = entering;
    fault_next          = fault;
    config_pending_next = pending_now;
    bus_word_next       = bus_word;
    shunt_word_next     = shunt_word;
    if (item.bus_idle) begin
      if (abort) begin
        phase_next    = PH_INIT;
        entering_next = 1'b1;
        fault_next    = 1'b0;
      end else begin
        unique case (phase)
          PH_INIT: begin
            if (pending_now) begin
              config_pending_next = 1'b0;
              phase_next          = PH_SETCFG;
            end else begin
              phase_next = PH_READBUS;
            end
          end
          PH_SETCFG: begin
            if (entering) fault_next = !item.bus_accepts;
            else          phase_next = PH_READCFG;
          end
          PH_READCFG: begin
            if (entering)                                fault_next = !item.bus_accepts;
            else if (item.read_data[15:8] != config_byte) phase_next = PH_SETCFG;
            else                                         phase_next = PH_INIT;
          end
          PH_READBUS: begin
            if (entering) begin
              fault_next = !item.bus_accepts;
            end else begin
              bus_word_next = item.read_data;
              phase_next    = PH_READSHUNT;
            end
          end
          PH_READSHUNT: begin
            if (entering) begin
              fault_next = !item.bus_accepts;
            end else begin
              shunt_word_next = item.read_data;
              phase_next      = PH_IDLE;
            end
          end
          PH_IDLE: phase_next = PH_INIT;
          default: phase_next = PH_INIT;
        endcase
        entering_next = (phase_next != phase);
      end
    end
  end

  // outputs
  always_comb begin
    result                   = '0;
    result.bus_voltage_raw   = bus_word_next;
    result.shunt_current_raw = shunt_word_next;
    if (item.bus_idle && !abort) begin
      result.data_valid = (phase_next == PH_IDLE) && !fault_next;
      if (entering) begin
        unique case (phase)
          PH_SETCFG: begin
            result.cmd_issue      = 1'b1;
            result.cmd_kind       = KIND_WRITE_CFG;
            result.cmd_reg        = REG_CONFIG;
            result.cmd_write_byte = config_byte;
            result.cmd_read_len   = LEN_NONE;
          end
          PH_READCFG: begin
            result.cmd_issue    = 1'b1;
            result.cmd_kind     = KIND_READ_CFG;
            result.cmd_reg      = REG_CONFIG;
            result.cmd_read_len = LEN_BYTE;
          end
          PH_READBUS: begin
            result.cmd_issue    = 1'b1;
            result.cmd_kind     = KIND_READ_BUS;
            result.cmd_reg      = REG_BUS;
            result.cmd_read_len = LEN_WORD;
          end
          PH_READSHUNT: begin
            result.cmd_issue    = 1'b1;
            result.cmd_kind     = KIND_READ_SHUNT;
            result.cmd_reg      = REG_SHUNT;
            result.cmd_read_len = LEN_WORD;
          end
          default: result.cmd_issue = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_INIT;
      entering       <= 1'b1;
      config_pending <= 1'b0;
      fault          <= 1'b0;
      bus_word       <= '0;
      shunt_word     <= '0;
    end else if (step) begin
      phase          <= phase_next;
      entering       <= entering_next;
      config_pending <= config_pending_next;
      fault          <= fault_next;
      bus_word       <= bus_word_next;
      shunt_word     <= shunt_word_next;
    end
  end

endmodule

// ===== hw/rtl/pmon_checker.sv =====
module pmon_checker import pmon_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        cmd_issue,
  input logic [1:0]  cmd_kind,
  input logic [7:0]  cmd_reg,
  input logic [7:0]  cmd_write_byte,
  input logic [1:0]  cmd_read_len,
  input logic        data_valid,
  input logic [15:0] bus_voltage_raw
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // no command means all command fields are zero
  a_idle_cmd_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !cmd_issue) |->
      (cmd_kind == 2'd0 && cmd_reg == 8'd0 && cmd_write_byte == 8'd0 &&
       cmd_read_len == 2'd0))
    else $error("command fields set without an issue");

  // reaching idle never coincides with a bus transaction
  a_valid_no_issue: assert property (@(posedge clk) disable iff (rst)
    (out_valid && data_valid) |-> !cmd_issue)
    else $error("data_valid together with a command");

  // command kind selects pointer and length
  a_kind_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && cmd_issue) |->
      ((cmd_kind == KIND_WRITE_CFG  && cmd_reg == REG_CONFIG && cmd_read_len == LEN_NONE) ||
       (cmd_kind == KIND_READ_CFG   && cmd_reg == REG_CONFIG && cmd_read_len == LEN_BYTE &&
        cmd_write_byte == 8'd0) ||
       (cmd_kind == KIND_READ_BUS   && cmd_reg == REG_BUS    && cmd_read_len == LEN_WORD &&
        cmd_write_byte == 8'd0) ||
       (cmd_kind == KIND_READ_SHUNT && cmd_reg == REG_SHUNT  && cmd_read_len == LEN_WORD &&
        cmd_write_byte == 8'd0)))
    else $error("inconsistent command fields");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(cmd_issue) &&
      $stable(data_valid) && $stable(bus_voltage_raw)))
    else $error("stalled result changed");

endmodule

bind i2c_power_monitor_poll_sequencer pmon_checker u_pmon_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .cmd_issue       (cmd_issue),
  .cmd_kind        (cmd_kind),
  .cmd_reg         (cmd_reg),
  .cmd_write_byte  (cmd_write_byte),
  .cmd_read_len    (cmd_read_len),
  .data_valid      (data_valid),
  .bus_voltage_raw (bus_voltage_raw)
);
